/* src/fla_pkg.sv */
// ----------------------------------------------------------------------------
// fla_pkg: shared definitions for the free list node allocator
// Pool geometry, field widths, status codes, counter and byte offset helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package fla_pkg;

	// pool geometry
	localparam int POOL_NODES = 1024;
	localparam int NODE_BYTES = 64;

	// field widths
	localparam int IDX_W  = 10;  // node index
	localparam int LINK_W = 11;  // node index or null marker
	localparam int CNT_W  = 11;  // node count, free total
	localparam int OFS_W  = 16;  // byte offset
	localparam int STAT_W = 2;

	localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(POOL_NODES);
	localparam logic [CNT_W-1:0]  POOL_CNT  = CNT_W'(POOL_NODES);

	// result status codes
	typedef enum logic [STAT_W-1:0] {
		STAT_OK      = 2'd0,
		STAT_NOSPACE = 2'd1,
		STAT_BADREQ  = 2'd2
	} status_t;

	// free total minus n, floored at zero
	function automatic logic [CNT_W-1:0] total_sub(input logic [CNT_W-1:0] total,
	                                               input logic [CNT_W-1:0] n);
		total_sub = (n >= total) ? '0 : total - n;
	endfunction

	// free total plus n, capped at the pool size
	function automatic logic [CNT_W-1:0] total_add(input logic [CNT_W-1:0] total,
	                                               input logic [CNT_W-1:0] n);
		logic [CNT_W:0] sum;
		sum = {1'b0, total} + {1'b0, n};
		total_add = (sum > {1'b0, POOL_CNT}) ? POOL_CNT : sum[CNT_W-1:0];
	endfunction

	// byte offset of a node, low bits
	function automatic logic [OFS_W-1:0] byte_offset_of(input logic [IDX_W-1:0] idx);
		logic [31:0] prod;
		prod = 32'(idx) * 32'(NODE_BYTES);
		byte_offset_of = prod[OFS_W-1:0];
	endfunction

endpackage

`default_nettype wire

/* src/fla_ram.sv */
// ----------------------------------------------------------------------------
// fla_ram: generic simple dual port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module fla_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

/* src/free_list_node_allocator.sv */
// ----------------------------------------------------------------------------
// free_list_node_allocator: linked free list pool allocator
// Pops single nodes, searches the list for runs of consecutive nodes and links
// freed ranges in front of the head. Links live in one next-pointer RAM.
// ----------------------------------------------------------------------------
//  channel  | signals                                     | handshake
//  ---------+---------------------------------------------+-------------------
//  command  | cmd, node_count, start_node                 | start && !busy
//  result   | status, node_index, byte_offset, free_count | done, one cycle
//
//  Rejected and empty-pool requests: result in the cycle after accept.
//  Single-node allocate: head link read, then pop.
//  Free of n nodes: one link write per node.
//  Run allocate: one link read per list step.
//  Reset clears head (null) and free total; the link RAM needs no clearing.
//  Results cannot be held off; busy stays high until the word is produced.
// ----------------------------------------------------------------------------
`default_nettype none

module free_list_node_allocator (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic                          cmd,
	input  wire logic [fla_pkg::CNT_W-1:0]     node_count,
	input  wire logic [fla_pkg::IDX_W-1:0]     start_node,
	output logic                               done,
	output logic      [fla_pkg::STAT_W-1:0]    status,
	output logic      [fla_pkg::IDX_W-1:0]     node_index,
	output logic      [fla_pkg::OFS_W-1:0]     byte_offset,
	output logic      [fla_pkg::CNT_W-1:0]     free_count
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_POP    = 5'b00010,
		ST_WALK   = 5'b00100,
		ST_FINISH = 5'b01000,
		ST_FREE   = 5'b10000
	} state_t;

	state_t state_q;

	logic [fla_pkg::LINK_W-1:0] head_q;
	logic [fla_pkg::CNT_W-1:0]  total_q;

	// request and walk registers
	logic [fla_pkg::CNT_W-1:0]  need_q;
	logic [fla_pkg::IDX_W-1:0]  addr_q;
	logic [fla_pkg::IDX_W-1:0]  start_q;
	logic [fla_pkg::CNT_W-1:0]  rem_q;
	logic [fla_pkg::IDX_W-1:0]  first_q;
	logic [fla_pkg::IDX_W-1:0]  last_q;
	logic [fla_pkg::IDX_W-1:0]  prev_q;
	logic                       have_prev_q;
	logic [fla_pkg::CNT_W-1:0]  run_q;
	logic [fla_pkg::CNT_W-1:0]  steps_q;

	// result word registers
	logic                       done_q;
	logic [fla_pkg::STAT_W-1:0] status_q;
	logic [fla_pkg::IDX_W-1:0]  index_q;
	logic [fla_pkg::OFS_W-1:0]  offset_q;
	logic [fla_pkg::CNT_W-1:0]  fcount_q;

	// link RAM ports
	logic                       mem_we;
	logic [fla_pkg::IDX_W-1:0]  mem_waddr;
	logic [fla_pkg::LINK_W-1:0] mem_wdata;
	logic [fla_pkg::IDX_W-1:0]  mem_raddr;
	logic [fla_pkg::LINK_W-1:0] mem_rdata;

	fla_ram #(
		.WIDTH(fla_pkg::LINK_W),
		.DEPTH(fla_pkg::POOL_NODES)
	) u_link_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// request checks at accept
	logic accept;
	logic bad_req;
	logic [fla_pkg::CNT_W:0] range_end;

	assign accept    = start && (state_q == ST_IDLE);
	assign range_end = (fla_pkg::CNT_W+1)'(start_node) + {1'b0, node_count};
	assign bad_req   = (node_count == '0) || (node_count > fla_pkg::POOL_CNT) ||
	                   (cmd && (range_end > {1'b0, fla_pkg::POOL_CNT}));

	// walk step decode: mem_rdata is the link of last_q
	logic [fla_pkg::LINK_W-1:0] last_inc;
	logic                       walk_stop;
	logic                       walk_adjacent;
	logic [fla_pkg::CNT_W-1:0]  run_inc;

	assign last_inc      = fla_pkg::LINK_W'(last_q) + 1'b1;
	assign walk_stop     = (mem_rdata == fla_pkg::LINK_NULL) ||
	                       (steps_q == fla_pkg::POOL_CNT);
	assign walk_adjacent = (last_inc == mem_rdata);
	assign run_inc       = run_q + 1'b1;

	// link RAM address and write selection
	always_comb begin
		mem_raddr = (state_q == ST_WALK) ? mem_rdata[fla_pkg::IDX_W-1:0]
		                                 : head_q[fla_pkg::IDX_W-1:0];
		mem_we    = 1'b0;
		mem_waddr = prev_q;
		mem_wdata = mem_rdata;
		case (state_q)
			ST_FREE: begin
				mem_we    = 1'b1;
				mem_waddr = addr_q;
				mem_wdata = (rem_q == fla_pkg::CNT_W'(1)) ? head_q
				          : fla_pkg::LINK_W'(addr_q) + 1'b1;
			end
			ST_FINISH: begin
				mem_we = have_prev_q;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= fla_pkg::LINK_NULL;
			total_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (bad_req) begin
							done_q <= 1'b1;
						end else if (cmd) begin
							state_q <= ST_FREE;
						end else if (head_q == fla_pkg::LINK_NULL) begin
							done_q <= 1'b1;
						end else if (node_count == fla_pkg::CNT_W'(1)) begin
							state_q <= ST_POP;
						end else begin
							state_q <= ST_WALK;
						end
					end
				end
				ST_POP: begin
					head_q  <= mem_rdata;
					total_q <= fla_pkg::total_sub(total_q, fla_pkg::CNT_W'(1));
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_WALK: begin
					if (walk_stop) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else if (walk_adjacent && (run_inc >= need_q)) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (!have_prev_q) begin
						head_q <= mem_rdata;
					end
					total_q <= fla_pkg::total_sub(total_q, run_q);
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_FREE: begin
					if (rem_q == fla_pkg::CNT_W'(1)) begin
						head_q  <= fla_pkg::LINK_W'(start_q);
						total_q <= fla_pkg::total_add(total_q, need_q);
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath and result word
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				need_q      <= node_count;
				rem_q       <= node_count;
				addr_q      <= start_node;
				start_q     <= start_node;
				first_q     <= head_q[fla_pkg::IDX_W-1:0];
				last_q      <= head_q[fla_pkg::IDX_W-1:0];
				have_prev_q <= 1'b0;
				run_q       <= fla_pkg::CNT_W'(1);
				steps_q     <= '0;
				index_q     <= '0;
				offset_q    <= '0;
				fcount_q    <= total_q;
				status_q    <= bad_req ? fla_pkg::STAT_BADREQ : fla_pkg::STAT_NOSPACE;
			end
			ST_POP: begin
				status_q <= fla_pkg::STAT_OK;
				index_q  <= head_q[fla_pkg::IDX_W-1:0];
				offset_q <= fla_pkg::byte_offset_of(head_q[fla_pkg::IDX_W-1:0]);
				fcount_q <= fla_pkg::total_sub(total_q, fla_pkg::CNT_W'(1));
			end
			ST_WALK: begin
				// failed walk keeps the no-space word loaded at accept
				if (!walk_stop) begin
					steps_q <= steps_q + 1'b1;
					last_q  <= mem_rdata[fla_pkg::IDX_W-1:0];
					if (walk_adjacent) begin
						run_q <= run_inc;
					end else begin
						have_prev_q <= 1'b1;
						prev_q      <= last_q;
						first_q     <= mem_rdata[fla_pkg::IDX_W-1:0];
						run_q       <= fla_pkg::CNT_W'(1);
					end
				end
			end
			ST_FINISH: begin
				status_q <= fla_pkg::STAT_OK;
				index_q  <= first_q;
				offset_q <= fla_pkg::byte_offset_of(first_q);
				fcount_q <= fla_pkg::total_sub(total_q, run_q);
			end
			ST_FREE: begin
				addr_q   <= addr_q + 1'b1;
				rem_q    <= rem_q - 1'b1;
				status_q <= fla_pkg::STAT_OK;
				fcount_q <= fla_pkg::total_add(total_q, need_q);
			end
			default: begin
				status_q <= fla_pkg::STAT_NOSPACE;
			end
		endcase
	end

	assign busy        = (state_q != ST_IDLE);
	assign done        = done_q;
	assign status      = status_q;
	assign node_index  = index_q;
	assign byte_offset = offset_q;
	assign free_count  = fcount_q;

endmodule

`default_nettype wire
